FILE: rtl/core/hsq_pkg.sv
// Shared types and constants for the Hall sensor qualifier.
`default_nettype none

package hsq_pkg;

   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned RUN_W   = 4;
   localparam int unsigned TIME_W  = 16;

   // Operation codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_EDGE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEED    = 2'd2;

   // Hall codes that no healthy sensor set can produce.
   localparam logic [CODE_W-1:0] CODE_LOW  = 3'b000;
   localparam logic [CODE_W-1:0] CODE_HIGH = 3'b111;

   localparam logic [RUN_W-1:0] CONFIRM_RESET = 4'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CODE_W-1:0] read_first;
      logic [CODE_W-1:0] read_second;
      logic [CODE_W-1:0] read_third;
      logic [TIME_W-1:0] now_ms;
   } hsq_item_type;

   typedef struct packed {
      logic              edge_seen;
      logic [CODE_W-1:0] hall_state;
      logic              invalid_fault;
      logic [TIME_W-1:0] ms_since_edge;
   } hsq_result_type;

endpackage : hsq_pkg

`default_nettype wire

FILE: rtl/core/hsq_core.sv
// Qualification logic and the sensor state registers it updates.
`default_nettype none

module hsq_core
   import hsq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire hsq_item_type   item,
   input  wire logic [RUN_W-1:0] confirm_count,
   output hsq_result_type      result
);

   logic [CODE_W-1:0] state_ff, state_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [TIME_W-1:0] last_edge_ff, last_edge_in;

   logic              qual_op;
   logic              agree;
   logic              illegal;
   logic              run_below;
   logic [RUN_W-1:0]  run_inc;
   logic              changed;
   logic              edge_hit;
   logic              fault;

   always_comb begin
      qual_op   = (item.func == FUNC_EDGE) || (item.func == FUNC_SEED);
      agree     = (item.read_first == item.read_second) &&
                  (item.read_second == item.read_third);
      illegal   = (item.read_first == CODE_LOW) || (item.read_first == CODE_HIGH);
      run_below = run_ff < confirm_count;
      run_inc   = run_ff + RUN_W'(1);

      run_in = run_ff;
      fault  = 1'b0;
      if (qual_op && agree) begin
         if (illegal) begin
            if (run_below) begin
               run_in = run_inc;
               fault  = (run_inc == confirm_count);
            end
         end else begin
            run_in = '0;
         end
      end

      changed  = qual_op && agree && !illegal && (item.read_first != state_ff);
      edge_hit = changed && (item.func == FUNC_EDGE);
      state_in = changed ? item.read_first : state_ff;

      // A restart and an accepted edge both move the timing reference to now.
      if (edge_hit || (item.func == FUNC_RESTART)) begin
         last_edge_in = item.now_ms;
      end else begin
         last_edge_in = last_edge_ff;
      end

      result.edge_seen     = edge_hit;
      result.hall_state    = state_in;
      result.invalid_fault = fault;
      result.ms_since_edge = item.now_ms - last_edge_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         run_ff       <= '0;
         last_edge_ff <= '0;
      end else if (advance) begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         last_edge_ff <= last_edge_in;
      end
   end

   a_fault_at_count: assert property (@(posedge clock) disable iff (reset)
      (advance && fault) |=> (run_ff == $past(confirm_count)))
      else $error("invalid fault raised without the run reaching the count");

   a_edge_zero_age: assert property (@(posedge clock) disable iff (reset)
      (advance && edge_hit) |-> (result.ms_since_edge == '0))
      else $error("accepted edge does not restart the edge age");

   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff != CODE_HIGH))
      else $error("stored hall state holds an illegal code");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(state_ff) && $stable(run_ff) && $stable(last_edge_ff)))
      else $error("sensor state changed without an item");

endmodule : hsq_core

`default_nettype wire

FILE: rtl/core/hall_sensor_qualifier.sv
// Top level of the Hall sensor qualifier: input register, result register, config.
//
// The qualifier takes one item per clock while the input is not stalled and
// returns exactly one result per item. An accepted item lands in an input
// register. When the result register is free, the qualification logic updates
// the stored hall state, invalid run counter and edge time and loads the result
// register, which presents the result until it is taken.
// Throughput is one item per cycle while not stalled, set by the single pass
// through the qualification logic between the two registers. The input stalls
// only while both registers hold an item and the result is stalled. The invalid
// confirm count resets to 3 and should be written only while no item is in flight.
`default_nettype none

module hall_sensor_qualifier
   import hsq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [CODE_W-1:0] req_read_first,
   input  wire logic [CODE_W-1:0] req_read_second,
   input  wire logic [CODE_W-1:0] req_read_third,
   input  wire logic [TIME_W-1:0] req_now_ms,

   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_edge_seen,
   output      logic [CODE_W-1:0] rsp_hall_state,
   output      logic              rsp_invalid_fault,
   output      logic [TIME_W-1:0] rsp_ms_since_edge,

   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [RUN_W-1:0]  csr_invalid_confirm_count
);

   logic             in_valid_ff, in_valid_in;
   hsq_item_type     in_item_ff;
   logic             out_valid_ff, out_valid_in;
   hsq_result_type   out_result_ff;
   logic [RUN_W-1:0] confirm_ff;

   logic             out_free;
   logic             advance;
   logic             req_take;
   hsq_result_type   core_result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   hsq_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (in_item_ff),
      .confirm_count (confirm_ff),
      .result        (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         confirm_ff   <= CONFIRM_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            confirm_ff <= csr_invalid_confirm_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{func:        req_func,
                         read_first:  req_read_first,
                         read_second: req_read_second,
                         read_third:  req_read_third,
                         now_ms:      req_now_ms};
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_edge_seen     = out_result_ff.edge_seen;
   assign rsp_hall_state    = out_result_ff.hall_state;
   assign rsp_invalid_fault = out_result_ff.invalid_fault;
   assign rsp_ms_since_edge = out_result_ff.ms_since_edge;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled while the pipeline has room");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item left the input register without reaching the output");

   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_result_ff)))
      else $error("stalled result was overwritten or dropped");

endmodule : hall_sensor_qualifier

`default_nettype wire
